@@ design/rmd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_pkg: shared types, constants and the microcode ROM
// Holds the request/response structs, the round tables, the control word
// layout and the function that returns one control word per program step.
// ----------------------------------------------------------------------------
package rmd_pkg;

  localparam int unsigned PcW    = 7;
  localparam int unsigned Steps  = 80;

  // Program layout
  localparam logic [PcW-1:0] PcWait      = 7'd0;
  localparam logic [PcW-1:0] PcPrime     = 7'd1;
  localparam logic [PcW-1:0] PcFirstStep = 7'd2;
  localparam logic [PcW-1:0] PcLastStep  = 7'd81;
  localparam logic [PcW-1:0] PcFinish    = 7'd82;

  localparam logic [31:0] InitH0 = 32'h67452301;
  localparam logic [31:0] InitH1 = 32'hEFCDAB89;
  localparam logic [31:0] InitH2 = 32'h98BADCFE;
  localparam logic [31:0] InitH3 = 32'h10325476;
  localparam logic [31:0] InitH4 = 32'hC3D2E1F0;

  localparam logic [31:0] PadMarker = 32'h0000_0080;
  localparam logic [31:0] BitLength = 32'h0000_0100;

  typedef struct packed {
    logic [31:0] message_word_0;
    logic [31:0] message_word_1;
    logic [31:0] message_word_2;
    logic [31:0] message_word_3;
    logic [31:0] message_word_4;
    logic [31:0] message_word_5;
    logic [31:0] message_word_6;
    logic [31:0] message_word_7;
  } rmd_in_t;

  typedef struct packed {
    logic [31:0] digest_word_0;
    logic [31:0] digest_word_1;
    logic [31:0] digest_word_2;
    logic [31:0] digest_word_3;
    logic [31:0] digest_word_4;
  } rmd_out_t;

  typedef logic [7:0][31:0] rmd_msg_t;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_PRIME,
    OP_ROUND,
    OP_FINISH
  } rmd_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ON_ACCEPT,
    JMP_ON_SLOT
  } rmd_jmp_e;

  typedef struct packed {
    rmd_op_e        op;
    rmd_jmp_e       jmp;
    logic [PcW-1:0] target;
    logic [3:0]     sel_l;
    logic [3:0]     sel_r;
    logic [4:0]     rot_l;
    logic [4:0]     rot_r;
    logic [2:0]     grp;
  } rmd_cw_t;

  // Sequencer to datapath control bundle
  typedef struct packed {
    logic       load;
    logic       round;
    logic       finish;
    logic [3:0] fetch_sel_l;
    logic [3:0] fetch_sel_r;
    logic [2:0] fetch_grp;
    logic [4:0] rot_l;
    logic [4:0] rot_r;
    logic [2:0] grp;
  } rmd_ctrl_t;

  localparam logic [0:Steps-1][3:0] SelL = {
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13
  };

  localparam logic [0:Steps-1][3:0] SelR = {
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
  };

  localparam logic [0:Steps-1][4:0] RotL = {
    5'd11, 5'd14, 5'd15, 5'd12, 5'd5, 5'd8, 5'd7, 5'd9,
    5'd11, 5'd13, 5'd14, 5'd15, 5'd6, 5'd7, 5'd9, 5'd8,
    5'd7, 5'd6, 5'd8, 5'd13, 5'd11, 5'd9, 5'd7, 5'd15,
    5'd7, 5'd12, 5'd15, 5'd9, 5'd11, 5'd7, 5'd13, 5'd12,
    5'd11, 5'd13, 5'd6, 5'd7, 5'd14, 5'd9, 5'd13, 5'd15,
    5'd14, 5'd8, 5'd13, 5'd6, 5'd5, 5'd12, 5'd7, 5'd5,
    5'd11, 5'd12, 5'd14, 5'd15, 5'd14, 5'd15, 5'd9, 5'd8,
    5'd9, 5'd14, 5'd5, 5'd6, 5'd8, 5'd6, 5'd5, 5'd12,
    5'd9, 5'd15, 5'd5, 5'd11, 5'd6, 5'd8, 5'd13, 5'd12,
    5'd5, 5'd12, 5'd13, 5'd14, 5'd11, 5'd8, 5'd5, 5'd6
  };

  localparam logic [0:Steps-1][4:0] RotR = {
    5'd8, 5'd9, 5'd9, 5'd11, 5'd13, 5'd15, 5'd15, 5'd5,
    5'd7, 5'd7, 5'd8, 5'd11, 5'd14, 5'd14, 5'd12, 5'd6,
    5'd9, 5'd13, 5'd15, 5'd7, 5'd12, 5'd8, 5'd9, 5'd11,
    5'd7, 5'd7, 5'd12, 5'd7, 5'd6, 5'd15, 5'd13, 5'd11,
    5'd9, 5'd7, 5'd15, 5'd11, 5'd8, 5'd6, 5'd6, 5'd14,
    5'd12, 5'd13, 5'd5, 5'd14, 5'd13, 5'd13, 5'd7, 5'd5,
    5'd15, 5'd5, 5'd8, 5'd11, 5'd14, 5'd14, 5'd6, 5'd14,
    5'd6, 5'd9, 5'd12, 5'd9, 5'd12, 5'd5, 5'd15, 5'd8,
    5'd8, 5'd5, 5'd12, 5'd9, 5'd12, 5'd5, 5'd14, 5'd6,
    5'd8, 5'd13, 5'd6, 5'd5, 5'd15, 5'd13, 5'd11, 5'd11
  };

  function automatic logic [31:0] k_left(input logic [2:0] g);
    logic [31:0] k;
    case (g)
      3'd0:    k = 32'h00000000;
      3'd1:    k = 32'h5A827999;
      3'd2:    k = 32'h6ED9EBA1;
      3'd3:    k = 32'h8F1BBCDC;
      default: k = 32'hA953FD4E;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] k_right(input logic [2:0] g);
    logic [31:0] k;
    case (g)
      3'd0:    k = 32'h50A28BE6;
      3'd1:    k = 32'h5C4DD124;
      3'd2:    k = 32'h6D703EF3;
      3'd3:    k = 32'h7A6D76E9;
      default: k = 32'h00000000;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] bfun(input logic [2:0] g, input logic [31:0] x,
                                       input logic [31:0] y, input logic [31:0] z);
    logic [31:0] f;
    case (g)
      3'd0:    f = x ^ y ^ z;
      3'd1:    f = (x & y) | (~x & z);
      3'd2:    f = (x | ~y) ^ z;
      3'd3:    f = (x & z) | (y & ~z);
      default: f = x ^ (y | ~z);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // Microcode ROM: wait for a request, prime the word fetch, 80 round steps,
  // then hand off the digest and return to the wait step.
  function automatic rmd_cw_t rmd_rom(input logic [PcW-1:0] pc);
    rmd_cw_t     cw;
    logic [6:0]  idx;
    cw        = '0;
    cw.op     = OP_WAIT;
    cw.jmp    = JMP_NEXT;
    cw.target = PcWait;
    idx       = pc - PcFirstStep;
    if (pc == PcWait) begin
      cw.op  = OP_WAIT;
      cw.jmp = JMP_ON_ACCEPT;
    end else if (pc == PcPrime) begin
      cw.op  = OP_PRIME;
      cw.jmp = JMP_NEXT;
    end else if (pc >= PcFirstStep && pc <= PcLastStep) begin
      cw.op    = OP_ROUND;
      cw.jmp   = JMP_NEXT;
      cw.sel_l = SelL[idx];
      cw.sel_r = SelR[idx];
      cw.rot_l = RotL[idx];
      cw.rot_r = RotR[idx];
      cw.grp   = 3'(idx >> 4);
    end else if (pc == PcFinish) begin
      cw.op     = OP_FINISH;
      cw.jmp    = JMP_ON_SLOT;
      cw.target = PcWait;
    end else begin
      cw.op     = OP_FINISH;
      cw.jmp    = JMP_ON_SLOT;
      cw.target = PcWait;
    end
    return cw;
  endfunction

endpackage
`default_nettype wire

@@ design/rmd_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_seq: microcode sequencer
// Steps a program counter through the control ROM and decodes each control
// word into datapath strobes, with conditional holds and jumps.
// ----------------------------------------------------------------------------
module rmd_seq import rmd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      slot_free_i,
  output logic           in_ready_o,
  output rmd_ctrl_t      ctrl_o
);

  logic [PcW-1:0] pc_q, pc_d;
  rmd_cw_t        cw, cw_next;
  logic           accept;

  assign cw         = rmd_rom(pc_q);
  assign in_ready_o = (cw.op == OP_WAIT);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    case (cw.jmp)
      JMP_NEXT:      pc_d = pc_q + 1'b1;
      JMP_ON_ACCEPT: pc_d = accept ? pc_q + 1'b1 : pc_q;
      JMP_ON_SLOT:   pc_d = slot_free_i ? cw.target : pc_q;
      default:       pc_d = PcWait;
    endcase
  end

  // Look ahead one step so the datapath can register the next message word.
  assign cw_next = rmd_rom(pc_d);

  always_comb begin
    ctrl_o.load        = accept;
    ctrl_o.round       = (cw.op == OP_ROUND);
    ctrl_o.finish      = (cw.op == OP_FINISH) && slot_free_i;
    ctrl_o.fetch_sel_l = cw_next.sel_l;
    ctrl_o.fetch_sel_r = cw_next.sel_r;
    ctrl_o.fetch_grp   = cw_next.grp;
    ctrl_o.rot_l       = cw.rot_l;
    ctrl_o.rot_r       = cw.rot_r;
    ctrl_o.grp         = cw.grp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

@@ design/rmd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_dp: compression datapath
// Message word bank with registered fetch, left and right chaining lines,
// one step of each line per cycle, and the final digest register.
// ----------------------------------------------------------------------------
module rmd_dp import rmd_pkg::*; (
  input  wire logic      clk_i,
  input  wire rmd_in_t   in_req_i,
  input  wire rmd_ctrl_t ctrl_i,
  output rmd_out_t       digest_o
);

  rmd_msg_t    msg_q, msg_d;
  logic [31:0] wk_l_q, wk_r_q;
  logic [31:0] la_q, lb_q, lc_q, ld_q, le_q;
  logic [31:0] ra_q, rb_q, rc_q, rd_q, re_q;
  logic [31:0] t_l, t_r;
  logic [2:0]  grp_r;
  rmd_out_t    dig_q, dig_d;

  function automatic logic [31:0] blk_word(input rmd_msg_t m, input logic [3:0] idx);
    logic [31:0] w;
    case (idx) inside
      [4'd0:4'd7]: w = m[idx[2:0]];
      4'd8:        w = PadMarker;
      4'd14:       w = BitLength;
      default:     w = '0;
    endcase
    return w;
  endfunction

  always_comb begin
    msg_d[0] = swap32(in_req_i.message_word_0);
    msg_d[1] = swap32(in_req_i.message_word_1);
    msg_d[2] = swap32(in_req_i.message_word_2);
    msg_d[3] = swap32(in_req_i.message_word_3);
    msg_d[4] = swap32(in_req_i.message_word_4);
    msg_d[5] = swap32(in_req_i.message_word_5);
    msg_d[6] = swap32(in_req_i.message_word_6);
    msg_d[7] = swap32(in_req_i.message_word_7);
  end

  assign grp_r = 3'd4 - ctrl_i.grp;

  assign t_l = rotl32(la_q + bfun(ctrl_i.grp, lb_q, lc_q, ld_q) + wk_l_q, ctrl_i.rot_l) + le_q;
  assign t_r = rotl32(ra_q + bfun(grp_r, rb_q, rc_q, rd_q) + wk_r_q, ctrl_i.rot_r) + re_q;

  always_comb begin
    dig_d.digest_word_0 = InitH1 + lc_q + rd_q;
    dig_d.digest_word_1 = InitH2 + ld_q + re_q;
    dig_d.digest_word_2 = InitH3 + le_q + ra_q;
    dig_d.digest_word_3 = InitH4 + la_q + rb_q;
    dig_d.digest_word_4 = InitH0 + lb_q + rc_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      msg_q <= msg_d;
    end
    // Fetch next step's word with its round constant already folded in
    wk_l_q <= blk_word(msg_q, ctrl_i.fetch_sel_l) + k_left(ctrl_i.fetch_grp);
    wk_r_q <= blk_word(msg_q, ctrl_i.fetch_sel_r) + k_right(ctrl_i.fetch_grp);

    if (ctrl_i.load) begin
      la_q <= InitH0; lb_q <= InitH1; lc_q <= InitH2; ld_q <= InitH3; le_q <= InitH4;
      ra_q <= InitH0; rb_q <= InitH1; rc_q <= InitH2; rd_q <= InitH3; re_q <= InitH4;
    end else if (ctrl_i.round) begin
      la_q <= le_q; le_q <= ld_q; ld_q <= rotl32(lc_q, 5'd10); lc_q <= lb_q; lb_q <= t_l;
      ra_q <= re_q; re_q <= rd_q; rd_q <= rotl32(rc_q, 5'd10); rc_q <= rb_q; rb_q <= t_r;
    end

    if (ctrl_i.finish) begin
      dig_q <= dig_d;
    end
  end

  assign digest_o = dig_q;

endmodule
`default_nettype wire

@@ design/ripemd160_hash_32byte_message_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ripemd160_hash_32byte_message_top: RIPEMD-160 of one 32-byte message
// Hashes eight big-endian message words and returns the five digest words.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid_i / in_ready_o carry in_req_i, eight 32-bit
//   big-endian message words. Response channel: out_valid_o / out_ready_i
//   carry out_rsp_o, the five digest words h0..h4.
//   A request is taken only while the sequencer sits on its wait step.
//   It then runs one prime step (first word fetch) and 80 round steps, each
//   advancing the left and right lines by one step, then a finish step that
//   loads the digest into the output register.
//   out_valid_o rises once the finish step has loaded the digest register.
//   Requests do not overlap: the next one is taken only on the wait step,
//   as the single shared round unit is stepped through all 80 rounds.
//   The next request is accepted while a finished response still waits in
//   the output register; if the receiver stalls longer, the finish step
//   holds until the register drains, so nothing is dropped or overwritten.
//   Reset returns the sequencer to its wait step and clears out_valid_o.
//   No state is kept between messages.
// ----------------------------------------------------------------------------
module ripemd160_hash_32byte_message_top import rmd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire rmd_in_t in_req_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output rmd_out_t     out_rsp_o
);

  rmd_ctrl_t ctrl;
  logic      out_valid_q, out_valid_d;
  logic      slot_free;

  // The output slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  rmd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .slot_free_i (slot_free),
    .in_ready_o  (in_ready_o),
    .ctrl_o      (ctrl)
  );

  rmd_dp u_dp (
    .clk_i    (clk_i),
    .in_req_i (in_req_i),
    .ctrl_i   (ctrl),
    .digest_o (out_rsp_o)
  );

  // Set on finish, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
